// ----- rtl/core/lbpse_pkg.sv -----
// Shared types and constants of the blink-pattern LED encoder.
package lbpse_pkg;

  // Default table depth.
  localparam int MAX_LEDS_DEF = 64;

  // Command codes.
  localparam logic [2:0] CMD_SET_STATE     = 3'd0;
  localparam logic [2:0] CMD_SET_INTENSITY = 3'd1;
  localparam logic [2:0] CMD_SET_COLOR     = 3'd2;
  localparam logic [2:0] CMD_CONFIG_ON_OFF = 3'd3;
  localparam logic [2:0] CMD_SET_PATTERN   = 3'd4;
  localparam logic [2:0] CMD_REFRESH       = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LED_COUNT = 2'd0;
  localparam logic [1:0] CFG_CODE_ONE  = 2'd1;
  localparam logic [1:0] CFG_CODE_ZERO = 2'd2;

  // Configuration reset values.
  localparam logic [6:0] LED_COUNT_RESET = 7'd64;
  localparam logic [7:0] CODE_RESET      = 8'd0;

  // Channel scaling: floor(p / 100) is (p * 5243) >> 19 for every product
  // below 25600, and products of 25600 or more saturate.
  localparam logic [12:0] RECIP_FACTOR = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;
  localparam logic [15:0] SAT_PRODUCT  = 16'd25600;
  localparam logic [7:0]  CHAN_MAX     = 8'hFF;

  // Colour bits per LED.
  localparam logic [4:0] WORD_BITS = 5'd24;

  // One command transfer.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  led_index;
    logic        force_on;
    logic [7:0]  level_percent;
    logic [23:0] on_color;
    logic [23:0] off_color;
    logic [7:0]  on_ticks;
    logic [7:0]  off_ticks;
  } cmd_item_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] code_byte;
    logic [7:0] out_led;
    logic       last;
  } res_item_t;

  // One configuration write.
  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] wdata;
  } cfg_item_t;

  // One table entry.
  typedef struct packed {
    logic [7:0]  lit_ticks;
    logic [7:0]  dark_ticks;
    logic [8:0]  blink_timer;
    logic [23:0] color_lit;
    logic [23:0] color_dark;
    logic [7:0]  percent;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    lit_ticks:   8'd0,
    dark_ticks:  8'd0,
    blink_timer: 9'd0,
    color_lit:   24'h0000FF,
    color_dark:  24'h000000,
    percent:     8'd100
  };

  // Request to the channel scaler.
  typedef struct packed {
    logic        start;
    logic [23:0] grb;
    logic [7:0]  pct;
  } scale_req_t;

  // Load request to the serialiser.
  typedef struct packed {
    logic        load;
    logic [23:0] word;
    logic [7:0]  led;
  } shift_load_t;

endpackage

// ----- rtl/core/lbpse_chan_if.sv -----
// Valid/ready channel carrying one payload per transfer.
interface lbpse_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/led_blink_pattern_serial_encoder.sv -----
// Refresh: the serialiser sends 24 code bytes, one per cycle while the receiver
// is ready. The sequencer takes the next command while those bytes go out; a
// later refresh waits in its load state until the last byte has gone, so
// receiver stalls hold it back. Other commands pass through the read and modify
// states only. Reset clears control state, the configuration registers and a
// valid flag per table entry at once, so no clearing pass follows reset.
module led_blink_pattern_serial_encoder #(
  parameter int MAX_LEDS = lbpse_pkg::MAX_LEDS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lbpse_chan_if.sink   cfg_i,
  lbpse_chan_if.sink   cmd_i,
  lbpse_chan_if.source res_o
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0]               state_q, state_d;
  lbpse_pkg::cmd_item_t     item_q;
  logic [6:0]               led_count_q;
  logic [7:0]               code_one_q;
  logic [7:0]               code_zero_q;
  logic [MAX_LEDS-1:0]      valid_q;

  logic [AW-1:0]            addr;
  logic                     hit;
  logic                     cmd_ok;
  logic                     ram_re;
  logic                     ram_we;
  logic [lbpse_pkg::ENTRY_W-1:0] ram_rdata;
  lbpse_pkg::entry_t        cur;
  lbpse_pkg::entry_t        nxt;
  logic                     lit_now;
  logic [8:0]               period;
  logic [9:0]               tick;
  logic [23:0]              col;
  lbpse_pkg::scale_req_t    scl_req;
  logic                     scl_done;
  logic [23:0]              scl_word;
  lbpse_pkg::shift_load_t   shift_ld;
  logic                     shift_busy;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= lbpse_pkg::LED_COUNT_RESET;
      code_one_q  <= lbpse_pkg::CODE_RESET;
      code_zero_q <= lbpse_pkg::CODE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        lbpse_pkg::CFG_LED_COUNT: led_count_q <= cfg_i.data.wdata[6:0];
        lbpse_pkg::CFG_CODE_ONE:  code_one_q  <= cfg_i.data.wdata;
        lbpse_pkg::CFG_CODE_ZERO: code_zero_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // Command capture.
  assign cmd_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      item_q <= cmd_i.data;
    end
  end

  // Range and command code checks.
  assign addr = item_q.led_index[AW-1:0];
  assign hit  = ({1'b0, item_q.led_index} < {2'b00, led_count_q})
             && ({1'b0, item_q.led_index} < 9'(MAX_LEDS));

  always_comb begin
    unique case (item_q.cmd) inside
      lbpse_pkg::CMD_SET_STATE, lbpse_pkg::CMD_SET_INTENSITY,
      lbpse_pkg::CMD_SET_COLOR, lbpse_pkg::CMD_CONFIG_ON_OFF,
      lbpse_pkg::CMD_SET_PATTERN, lbpse_pkg::CMD_REFRESH: cmd_ok = 1'b1;
      default: cmd_ok = 1'b0;
    endcase
  end

  // LED table.
  lbpse_ram #(
    .WIDTH (lbpse_pkg::ENTRY_W),
    .DEPTH (MAX_LEDS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (nxt),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[addr] <= 1'b1;
    end
  end

  assign cur = valid_q[addr] ? lbpse_pkg::entry_t'(ram_rdata) : lbpse_pkg::ENTRY_RESET;

  // Blink timer step and colour choice.
  always_comb begin
    period  = {1'b0, cur.lit_ticks} + {1'b0, cur.dark_ticks};
    tick    = {1'b0, cur.blink_timer} + 10'd1;
    lit_now = 1'b0;
    if (cur.lit_ticks == 8'd0) begin
      lit_now = 1'b0;
    end else if (cur.dark_ticks == 8'd0) begin
      lit_now = 1'b1;
    end else begin
      lit_now = (cur.blink_timer < {1'b0, cur.lit_ticks});
    end
  end

  assign col = lit_now ? cur.color_lit : cur.color_dark;

  // Entry update for each command.
  always_comb begin
    nxt    = cur;
    ram_we = 1'b0;
    if (state_q == ST_MOD) begin
      case (item_q.cmd)
        lbpse_pkg::CMD_SET_STATE: begin
          nxt.lit_ticks  = {7'd0, item_q.force_on};
          nxt.dark_ticks = {7'd0, !item_q.force_on};
          ram_we         = 1'b1;
        end
        lbpse_pkg::CMD_SET_INTENSITY: begin
          nxt.percent = item_q.level_percent;
          ram_we      = 1'b1;
        end
        lbpse_pkg::CMD_SET_COLOR: begin
          nxt.color_lit  = item_q.on_color;
          nxt.percent    = item_q.level_percent;
          nxt.lit_ticks  = 8'd1;
          nxt.dark_ticks = 8'd0;
          ram_we         = 1'b1;
        end
        lbpse_pkg::CMD_CONFIG_ON_OFF: begin
          nxt.color_lit  = item_q.on_color;
          nxt.color_dark = item_q.off_color;
          nxt.percent    = item_q.level_percent;
          ram_we         = 1'b1;
        end
        lbpse_pkg::CMD_SET_PATTERN: begin
          // An unchanged pattern keeps the timer running.
          if (cur.lit_ticks != item_q.on_ticks || cur.dark_ticks != item_q.off_ticks) begin
            nxt.lit_ticks   = item_q.on_ticks;
            nxt.dark_ticks  = item_q.off_ticks;
            nxt.blink_timer = 9'd0;
            ram_we          = 1'b1;
          end
        end
        lbpse_pkg::CMD_REFRESH: begin
          if (cur.lit_ticks != 8'd0 && cur.dark_ticks != 8'd0) begin
            nxt.blink_timer = (tick > {1'b0, period}) ? 9'd0 : tick[8:0];
            ram_we          = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    ram_re  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (hit && cmd_ok) begin
          ram_re  = 1'b1;
          state_d = ST_MOD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        state_d = (item_q.cmd == lbpse_pkg::CMD_REFRESH) ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        if (scl_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!shift_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Channel scaling in G, R, B order.
  assign scl_req.start = (state_q == ST_MOD) && (item_q.cmd == lbpse_pkg::CMD_REFRESH);
  assign scl_req.grb   = {col[15:8], col[23:16], col[7:0]};
  assign scl_req.pct   = cur.percent;

  lbpse_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scl_req),
    .done_o (scl_done),
    .word_o (scl_word)
  );

  // Serial output of the scaled word.
  assign shift_ld.load = (state_q == ST_LOAD) && !shift_busy;
  assign shift_ld.word = scl_word;
  assign shift_ld.led  = item_q.led_index;

  lbpse_shift u_shift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (shift_ld),
    .code_one_i  (code_one_q),
    .code_zero_i (code_zero_q),
    .busy_o      (shift_busy),
    .res_o       (res_o)
  );

`ifndef ASSERT_OFF
  // The serialiser is never reloaded while bytes are still pending.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_ld.load |-> !shift_busy)
    else $error("serialiser loaded while busy");

  // The last byte of an LED is followed by an idle output cycle.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.data.last) |=> !res_o.valid)
    else $error("result stream continues after last byte");

  // Table writes only go to entries in range.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (hit && (state_q == ST_MOD)))
    else $error("table write outside range");

  // The scaler only completes while the sequencer waits for it.
  a_done_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> (state_q == ST_SCALE))
    else $error("scaler completed outside scaling state");
`endif

endmodule

// ----- rtl/core/lbpse_ram.sv -----
// Simple dual-port RAM with a registered read.
module lbpse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/lbpse_scale.sv -----
// Scales the three colour channels by a percentage, one byte digit per cycle.
module lbpse_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lbpse_pkg::scale_req_t  req_i,
  output logic                   done_o,
  output logic [23:0]            word_o
);

  logic [23:0] src_q;
  logic [7:0]  pct_q;
  logic [1:0]  iss_q;
  logic [15:0] prod_q;
  logic        pv_q;
  logic [23:0] res_q;
  logic        done_q;
  logic [28:0] recip_prod;
  logic [7:0]  chan;

  // Control: bytes still to issue, product valid and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q  <= 2'd0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= (iss_q != 2'd0);
      done_q <= pv_q && (iss_q == 2'd0);
      if (req_i.start) begin
        iss_q <= 2'd3;
      end else if (iss_q != 2'd0) begin
        iss_q <= iss_q - 2'd1;
      end
    end
  end

  // Source shift register feeds the multiplier one channel at a time.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      src_q <= req_i.grb;
      pct_q <= req_i.pct;
    end else if (iss_q != 2'd0) begin
      src_q <= {src_q[15:0], 8'd0};
    end
    if (iss_q != 2'd0) begin
      prod_q <= 16'(src_q[23:16]) * 16'(pct_q);
    end
  end

  // Divide by 100 through the reciprocal, with saturation.
  assign recip_prod = 29'(prod_q) * 29'(lbpse_pkg::RECIP_FACTOR);
  assign chan = (prod_q >= lbpse_pkg::SAT_PRODUCT) ? lbpse_pkg::CHAN_MAX
              : recip_prod[lbpse_pkg::RECIP_SHIFT +: 8];

  // Result shift register collects the scaled channels in order.
  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      res_q <= {res_q[15:0], chan};
    end
  end

  assign done_o = done_q;
  assign word_o = res_q;

endmodule

// ----- rtl/core/lbpse_shift.sv -----
// Serialiser: sends one code byte for each colour bit, MSB first.
module lbpse_shift (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lbpse_pkg::shift_load_t   ld_i,
  input  logic [7:0]               code_one_i,
  input  logic [7:0]               code_zero_i,
  output logic                     busy_o,
  lbpse_chan_if.source             res_o
);

  logic [23:0] word_q;
  logic [7:0]  led_q;
  logic [4:0]  cnt_q;
  logic        xfer;

  assign xfer = res_o.valid && res_o.ready;

  // Bit counter: counts down the bits still to send.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (ld_i.load) begin
      cnt_q <= lbpse_pkg::WORD_BITS;
    end else if (xfer) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // Colour word shifts left by one bit per transfer.
  always_ff @(posedge clk_i) begin
    if (ld_i.load) begin
      word_q <= ld_i.word;
      led_q  <= ld_i.led;
    end else if (xfer) begin
      word_q <= {word_q[22:0], 1'b0};
    end
  end

  assign busy_o              = (cnt_q != 5'd0);
  assign res_o.valid         = busy_o;
  assign res_o.data.code_byte = word_q[23] ? code_one_i : code_zero_i;
  assign res_o.data.out_led  = led_q;
  assign res_o.data.last     = (cnt_q == 5'd1);

endmodule
